>>> hw/rtl/mspe_pkg.sv
// Package for the max-sum-pick-from-ends block: payload structs, sequencer
// codes and shared constants. No dependencies.
package mspe_pkg;

    localparam int ELEM_W           = 11;
    localparam int PICK_W           = 11;
    localparam int SUM_W            = 21;
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int SUM_MAX          = (2 ** (SUM_W - 1)) - 1;
    localparam int SUM_MIN          = -(2 ** (SUM_W - 1));
    localparam logic [PICK_W-1:0] PICK_RESET = PICK_W'(1);

    typedef struct packed {
        logic signed [ELEM_W-1:0] element_value;
        logic                     is_last;
    } item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] best_sum;
        logic                    too_few;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SWAP,
        ST_DRAIN,
        ST_REPORT
    } state_t;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_SUM,
        PEND_SWAP
    } pend_t;

endpackage

>>> hw/rtl/max_sum_pick_from_ends_top.sv
// Top level of the max-sum-pick-from-ends block: load sequencer, split search
// and result register. Depends on mspe_pkg and mspe_ram.
//
// Elements are loaded one per cycle (start high, busy low); busy stays low while
// loading. On the element marked is_last the block goes busy and walks the
// element RAM: it sums the first pick_count elements, then swaps pick_count
// times one prefix element for one suffix element through the RAM's two read
// ports, and finally drains the read pipeline and reports. When pick_count
// exceeds the loaded count or is zero, the walk is skipped and the block goes
// straight to report. The result shows on result for one cycle
// with done high and cannot be held off; a new transaction may start in that cycle.
module max_sum_pick_from_ends_top #(
    parameter int MAX_ELEMENTS = mspe_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  mspe_pkg::item_t                item,
    input  logic                           cfg_we,
    input  logic [mspe_pkg::PICK_W-1:0]    cfg_wdata,
    output logic                           done,
    output mspe_pkg::result_t              result
);

    localparam int AW      = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
    localparam int IW      = (CNT_W > mspe_pkg::PICK_W) ? CNT_W : mspe_pkg::PICK_W;
    localparam int ACC_RAW = mspe_pkg::ELEM_W + CNT_W;
    localparam int ACC_W   = (ACC_RAW > mspe_pkg::SUM_W + 1) ? ACC_RAW : mspe_pkg::SUM_W + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(mspe_pkg::SUM_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(mspe_pkg::SUM_MIN);

    mspe_pkg::state_t                state_reg, state_next;
    mspe_pkg::pend_t                 pend_reg, pend_next;
    logic [mspe_pkg::PICK_W-1:0]     pick_reg;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [CNT_W-1:0]                n_reg, n_next;
    logic [mspe_pkg::PICK_W-1:0]     k_reg, k_next;
    logic [mspe_pkg::PICK_W-1:0]     j_reg, j_next;
    logic                            few_reg, few_next;
    logic signed [ACC_W-1:0]         win_reg, win_next;
    logic signed [ACC_W-1:0]         best_reg, best_next;
    logic                            done_reg, done_next;
    mspe_pkg::result_t               result_reg, result_next;

    logic                            accept;
    logic                            room;
    logic [CNT_W-1:0]                n_new;
    logic                            few_new;
    logic                            ram_we;
    logic [AW-1:0]                   raddr_a, raddr_b;
    logic [mspe_pkg::ELEM_W-1:0]     rdata_a, rdata_b;
    logic signed [ACC_W-1:0]         a_ext, b_ext, swap_sum, sat_sum;
    logic [IW-1:0]                   j_ext, k_ext, n_ext, idx_a, idx_b;

    assign accept  = start && (state_reg == mspe_pkg::ST_IDLE);
    assign room    = count_reg < CNT_MAX;
    assign n_new   = room ? count_reg + CNT_W'(1) : count_reg;
    assign few_new = IW'(pick_reg) > IW'(n_new);
    assign ram_we  = accept && room;

    assign j_ext = IW'(j_reg);
    assign k_ext = IW'(k_reg);
    assign n_ext = IW'(n_reg);

    always_comb
    begin
        if (state_reg == mspe_pkg::ST_SWAP)
        begin
            idx_a = k_ext - j_ext;
            idx_b = n_ext - j_ext;
        end
        else
        begin
            idx_a = j_ext;
            idx_b = j_ext;
        end
    end

    assign raddr_a = idx_a[AW-1:0];
    assign raddr_b = idx_b[AW-1:0];

    mspe_ram #(
        .WIDTH (mspe_pkg::ELEM_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (count_reg[AW-1:0]),
        .wdata   (item.element_value),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    assign a_ext    = {{(ACC_W - mspe_pkg::ELEM_W){rdata_a[mspe_pkg::ELEM_W-1]}}, rdata_a};
    assign b_ext    = {{(ACC_W - mspe_pkg::ELEM_W){rdata_b[mspe_pkg::ELEM_W-1]}}, rdata_b};
    assign swap_sum = win_reg + b_ext - a_ext;

    always_comb
    begin
        if (best_reg > SAT_HI)
        begin
            sat_sum = SAT_HI;
        end
        else if (best_reg < SAT_LO)
        begin
            sat_sum = SAT_LO;
        end
        else
        begin
            sat_sum = best_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pend_next   = mspe_pkg::PEND_NONE;
        count_next  = count_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        few_next    = few_reg;
        win_next    = win_reg;
        best_next   = best_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        // data stage: read data of the previous cycle's issue
        case (pend_reg)
            mspe_pkg::PEND_SUM:
            begin
                win_next  = win_reg + a_ext;
                best_next = win_reg + a_ext;
            end
            mspe_pkg::PEND_SWAP:
            begin
                win_next = swap_sum;
                if (swap_sum > best_reg)
                begin
                    best_next = swap_sum;
                end
            end
            default:
            begin
            end
        endcase

        case (state_reg)
            mspe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.is_last)
                    begin
                        count_next = '0;
                        n_next     = n_new;
                        k_next     = pick_reg;
                        few_next   = few_new;
                        j_next     = '0;
                        win_next   = '0;
                        best_next  = '0;
                        if (few_new || (pick_reg == '0))
                        begin
                            state_next = mspe_pkg::ST_REPORT;
                        end
                        else
                        begin
                            state_next = mspe_pkg::ST_SUM;
                        end
                    end
                    else
                    begin
                        count_next = n_new;
                    end
                end
            end
            mspe_pkg::ST_SUM:
            begin
                pend_next = mspe_pkg::PEND_SUM;
                if (j_reg == k_reg - mspe_pkg::PICK_W'(1))
                begin
                    j_next     = mspe_pkg::PICK_W'(1);
                    state_next = mspe_pkg::ST_SWAP;
                end
                else
                begin
                    j_next = j_reg + mspe_pkg::PICK_W'(1);
                end
            end
            mspe_pkg::ST_SWAP:
            begin
                pend_next = mspe_pkg::PEND_SWAP;
                if (j_reg == k_reg)
                begin
                    state_next = mspe_pkg::ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg + mspe_pkg::PICK_W'(1);
                end
            end
            mspe_pkg::ST_DRAIN:
            begin
                state_next = mspe_pkg::ST_REPORT;
            end
            mspe_pkg::ST_REPORT:
            begin
                done_next            = 1'b1;
                result_next.best_sum = sat_sum[mspe_pkg::SUM_W-1:0];
                result_next.too_few  = few_reg;
                state_next           = mspe_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mspe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mspe_pkg::ST_IDLE;
            pend_reg  <= mspe_pkg::PEND_NONE;
            pick_reg  <= mspe_pkg::PICK_RESET;
            count_reg <= '0;
            done_reg  <= 1'b0;
            win_reg   <= '0;
            best_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            win_reg   <= win_next;
            best_reg  <= best_next;
            if (cfg_we)
            begin
                pick_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        k_reg      <= k_next;
        j_reg      <= j_next;
        few_reg    <= few_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != mspe_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == mspe_pkg::ST_REPORT))
        else $error("result strobe without report state");

    a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.too_few) |-> (result.best_sum == '0))
        else $error("too_few result carries nonzero sum");

    a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.is_last) |=> busy)
        else $error("last element did not start the search");

    a_pend_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != mspe_pkg::PEND_NONE) |->
            ($past(state_reg == mspe_pkg::ST_SUM) || $past(state_reg == mspe_pkg::ST_SWAP)))
        else $error("read data pending outside search");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("loaded count beyond store depth");

endmodule

>>> hw/rtl/mspe_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module mspe_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    output logic [WIDTH-1:0]                    rdata_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                    rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
